>>> design/rews_pkg.sv
package rews_pkg;

    // Field widths fixed by the item formats
    localparam int DELTA_W   = 16;
    localparam int DEB_W     = 10;
    localparam int LONG_W    = 14;
    localparam int TIMER_W   = 16;
    localparam int APB_W     = 32;
    localparam int APB_AW    = 3;

    // Quadrature phase codes {A, B}, in clockwise order
    localparam logic [1:0] PH_11 = 2'b11;
    localparam logic [1:0] PH_01 = 2'b01;
    localparam logic [1:0] PH_00 = 2'b00;
    localparam logic [1:0] PH_10 = 2'b10;

    // Register indexes (paddr[2])
    localparam logic REG_DEBOUNCE   = 1'b0;
    localparam logic REG_LONG_PRESS = 1'b1;

    localparam logic [DEB_W-1:0]  DEBOUNCE_RST   = 10'd50;
    localparam logic [LONG_W-1:0] LONG_PRESS_RST = 14'd600;

    typedef struct packed {
        logic pin_a;
        logic pin_b;
        logic switch_down;
        logic ms_tick;
        logic take;
    } t_in_item;

    typedef struct packed {
        logic signed [DELTA_W-1:0] delta;
        logic                      pressed;
        logic                      long_press;
        logic                      held;
    } t_out_item;

    typedef struct packed {
        logic [DEB_W-1:0]  deb_limit;
        logic [LONG_W-1:0] long_limit;
    } t_cfg;

    // True for one of the four clockwise Gray steps
    function automatic logic cw_step(input logic [1:0] from_ph, input logic [1:0] to_ph);
        logic hit;
        hit = ((from_ph == PH_11) && (to_ph == PH_01)) ||
              ((from_ph == PH_01) && (to_ph == PH_00)) ||
              ((from_ph == PH_00) && (to_ph == PH_10)) ||
              ((from_ph == PH_10) && (to_ph == PH_11));
        return hit;
    endfunction

endpackage

>>> design/rews_regs.sv
module rews_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rews_pkg::APB_AW-1:0] paddr,
    input  logic [rews_pkg::APB_W-1:0]  pwdata,
    output logic [rews_pkg::APB_W-1:0]  prdata,
    output logic                        pready,
    output rews_pkg::t_cfg              o_cfg
);
    import rews_pkg::*;

    logic [DEB_W-1:0]  r_debounce;
    logic [LONG_W-1:0] r_long_press;
    logic              wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= DEBOUNCE_RST;
            r_long_press <= LONG_PRESS_RST;
        end else if (wr_en) begin
            case (paddr[2])
                REG_DEBOUNCE:   r_debounce   <= pwdata[DEB_W-1:0];
                REG_LONG_PRESS: r_long_press <= pwdata[LONG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_DEBOUNCE:   prdata = APB_W'(r_debounce);
            REG_LONG_PRESS: prdata = APB_W'(r_long_press);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.deb_limit  = r_debounce;
    assign o_cfg.long_limit = r_long_press;

endmodule

>>> design/rews_quad.sv
module rews_quad #(
    parameter int TICKS_PER_DETENT = 4,
    parameter int COUNT_WIDTH      = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_step,
    input  logic [1:0]                          i_phase,
    input  logic                                i_take,
    output logic signed [rews_pkg::DELTA_W-1:0] o_delta
);
    import rews_pkg::*;

    localparam int CW = COUNT_WIDTH;
    localparam int RW = $clog2(TICKS_PER_DETENT) + 1;
    localparam int EW = (CW > DELTA_W) ? CW : DELTA_W;

    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [RW-1:0] R_TOP = RW'(TICKS_PER_DETENT - 1);
    localparam logic signed [RW-1:0] R_BOT = RW'(1 - TICKS_PER_DETENT);
    localparam logic signed [EW-1:0] D_MAX = EW'(32767);
    localparam logic signed [EW-1:0] D_MIN = EW'(-32768);
    localparam logic signed [EW-1:0] TPD   = EW'(TICKS_PER_DETENT);

    // Count kept together with its truncated quotient and remainder,
    // so the detent value never needs a divider.
    logic [1:0]             r_last_phase;
    logic signed [CW-1:0]   r_count, n_count;
    logic signed [CW-1:0]   r_quot, n_quot;
    logic signed [RW-1:0]   r_rem, n_rem;

    logic                   chg, cw, up, dn, neg, pos;
    logic signed [CW-1:0]   c_dec, q_dec;
    logic signed [EW-1:0]   q_ext, q_clamp, prod;

    always_comb begin
        chg   = (i_phase != r_last_phase);
        cw    = cw_step(r_last_phase, i_phase);
        up    = chg && cw && (r_count != C_MAX);
        dn    = chg && !cw && (r_count != C_MIN);
        neg   = r_count[CW-1];
        pos   = !neg && (r_count != '0);
        c_dec = r_count;
        q_dec = r_quot;
        n_rem = r_rem;

        if (up) begin
            c_dec = r_count + CW'(1);
            if (!neg) begin
                if (r_rem == R_TOP) begin
                    q_dec = r_quot + CW'(1);
                    n_rem = '0;
                end else begin
                    n_rem = r_rem + RW'(1);
                end
            end else begin
                if (r_rem == '0) begin
                    q_dec = r_quot + CW'(1);
                    n_rem = R_BOT;
                end else begin
                    n_rem = r_rem + RW'(1);
                end
            end
        end else if (dn) begin
            c_dec = r_count - CW'(1);
            if (pos) begin
                if (r_rem == '0) begin
                    q_dec = r_quot - CW'(1);
                    n_rem = R_TOP;
                end else begin
                    n_rem = r_rem - RW'(1);
                end
            end else begin
                if (r_rem == R_BOT) begin
                    q_dec = r_quot - CW'(1);
                    n_rem = '0;
                end else begin
                    n_rem = r_rem - RW'(1);
                end
            end
        end

        // Take: whole detents out, remainder stays
        q_ext = EW'(q_dec);
        if (q_ext > D_MAX) begin
            q_clamp = D_MAX;
        end else if (q_ext < D_MIN) begin
            q_clamp = D_MIN;
        end else begin
            q_clamp = q_ext;
        end
        prod = q_clamp * TPD;

        if (i_take) begin
            n_count = c_dec - CW'(prod);
            n_quot  = q_dec - CW'(q_clamp);
            o_delta = DELTA_W'(q_clamp);
        end else begin
            n_count = c_dec;
            n_quot  = q_dec;
            o_delta = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_phase <= PH_11;
            r_count      <= '0;
            r_quot       <= '0;
            r_rem        <= '0;
        end else if (i_step) begin
            r_last_phase <= i_phase;
            r_count      <= n_count;
            r_quot       <= n_quot;
            r_rem        <= n_rem;
        end
    end

endmodule

>>> design/rews_switch.sv
module rews_switch (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  logic           i_raw,
    input  logic           i_tick,
    input  logic           i_take,
    input  rews_pkg::t_cfg i_cfg,
    output logic           o_pressed,
    output logic           o_long_press,
    output logic           o_held
);
    import rews_pkg::*;

    logic               r_raw_prev;
    logic               r_state, n_state;
    logic [TIMER_W-1:0] r_stable, n_stable;
    logic [TIMER_W-1:0] r_press, n_press;
    logic               r_fired, n_fired;
    logic               r_pflag;
    logic               r_lflag;

    logic               raw_chg, edge_ok, press_edge, rel_edge, fire, fired_mid;
    logic [TIMER_W-1:0] press_inc;

    always_comb begin
        raw_chg = (i_raw != r_raw_prev);
        if (raw_chg) begin
            n_stable = '0;
        end else if (i_tick && (r_stable != '1)) begin
            n_stable = r_stable + TIMER_W'(1);
        end else begin
            n_stable = r_stable;
        end

        if (i_tick && r_state && (r_press != '1)) begin
            press_inc = r_press + TIMER_W'(1);
        end else begin
            press_inc = r_press;
        end

        edge_ok    = (n_stable > TIMER_W'(i_cfg.deb_limit));
        press_edge = edge_ok && i_raw && !r_state;
        rel_edge   = edge_ok && !i_raw && r_state;

        n_state   = press_edge ? 1'b1 : (rel_edge ? 1'b0 : r_state);
        n_press   = press_edge ? '0 : press_inc;
        fired_mid = press_edge ? 1'b0 : r_fired;

        fire    = n_state && !fired_mid && (n_press >= TIMER_W'(i_cfg.long_limit));
        n_fired = fired_mid || fire;

        o_pressed    = r_pflag || (rel_edge && !r_fired);
        o_long_press = r_lflag || fire;
        o_held       = n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_prev <= 1'b0;
            r_state    <= 1'b0;
            r_stable   <= '0;
            r_press    <= '0;
            r_fired    <= 1'b0;
            r_pflag    <= 1'b0;
            r_lflag    <= 1'b0;
        end else if (i_step) begin
            r_raw_prev <= i_raw;
            r_state    <= n_state;
            r_stable   <= n_stable;
            r_press    <= n_press;
            r_fired    <= n_fired;
            r_pflag    <= o_pressed && !i_take;
            r_lflag    <= o_long_press && !i_take;
        end
    end

endmodule

>>> design/rotary_encoder_with_switch_unit.sv
// Channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+---------------------------------
// in        | to block  | i_in_valid / o_in_ready    | i_in_item  (pins, switch, tick, take)
// out       | from block| o_out_valid / i_out_ready  | o_out_item (delta, flags, held)
// cfg       | to block  | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// One item per clock sustained while the out side does not stall. An
// accepted item is held in the input register; its encoder and switch
// update is computed from there and lands in the output register, from
// which the result is offered. Reset (i_rst_n low, synchronous) empties
// both registers and restores the counters, flags and register defaults.
// A stall on the out side holds the output register; one more item
// waits in the input register.
module rotary_encoder_with_switch_unit #(
    parameter int TICKS_PER_DETENT = 4,
    parameter int COUNT_WIDTH      = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input items
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  rews_pkg::t_in_item          i_in_item,
    // result items
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output rews_pkg::t_out_item         o_out_item,
    // register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rews_pkg::APB_AW-1:0] paddr,
    input  logic [rews_pkg::APB_W-1:0]  pwdata,
    output logic [rews_pkg::APB_W-1:0]  prdata,
    output logic                        pready
);
    import rews_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item n_out_item;
    t_cfg      cfg;

    logic      in_acc;
    logic      adv;     // item moves from input register to output register

    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;
    assign in_acc     = i_in_valid && o_in_ready;

    rews_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Quadrature count and detent take
    rews_quad #(
        .TICKS_PER_DETENT (TICKS_PER_DETENT),
        .COUNT_WIDTH      (COUNT_WIDTH)
    ) u_quad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (adv),
        .i_phase ({r_in_item.pin_a, r_in_item.pin_b}),
        .i_take  (r_in_item.take),
        .o_delta (n_out_item.delta)
    );

    // Switch debounce, short and long press
    rews_switch u_switch (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (adv),
        .i_raw        (r_in_item.switch_down),
        .i_tick       (r_in_item.ms_tick),
        .i_take       (r_in_item.take),
        .i_cfg        (cfg),
        .o_pressed    (n_out_item.pressed),
        .o_long_press (n_out_item.long_press),
        .o_held       (n_out_item.held)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_item <= i_in_item;
        end
        if (adv) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> design/rews_checker.sv
module rews_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input rews_pkg::t_out_item         o_out_item
);
    import rews_pkg::*;

    // No result survives reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // Input side never blocks while the output side can move
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid || i_out_ready |-> o_in_ready)
        else $error("input stalled with output free");

    // A fresh result follows an accepted item
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2))
        else $error("result without accepted item");

endmodule

bind rotary_encoder_with_switch_unit rews_checker u_rews_checker (.*);

>>> tb/sv/rews_readout_checker.sv
`timescale 1ns / 1ps

// Watches both item channels and the register port, predicts each readout
// and compares it with what the block returns.
module rews_readout_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  rews_pkg::t_in_item          i_in_item,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  rews_pkg::t_out_item         i_out_item,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic                        i_pready,
    input  logic [rews_pkg::APB_AW-1:0] i_paddr,
    input  logic [rews_pkg::APB_W-1:0]  i_pwdata,
    output int                          o_fail_count,
    output int                          o_pending
);
    import rews_pkg::*;

    localparam int DETENT_TICKS = 4;
    localparam logic signed [DELTA_W-1:0] TICK_MAX = 16'sh7FFF;
    localparam logic signed [DELTA_W-1:0] TICK_MIN = 16'sh8000;
    localparam logic [TIMER_W-1:0]        MS_MAX   = 16'hFFFF;

    // register copies
    logic [DEB_W-1:0]          deb_lim;
    logic [LONG_W-1:0]         long_lim;

    // encoder and switch state
    logic [1:0]                enc_ph;
    logic signed [DELTA_W-1:0] ticks;
    logic                      raw_q;
    logic                      sw_held;
    logic [TIMER_W-1:0]        quiet_ms;
    logic [TIMER_W-1:0]        hold_ms;
    logic                      long_done;
    logic                      short_evt;
    logic                      long_evt;

    t_out_item                 readout_due[$];

    // Decode one sample and return the readout it produces.
    function automatic t_out_item next_readout(input t_in_item s);
        logic [1:0]                ph;
        logic                      fwd;
        logic signed [DELTA_W-1:0] det;
        t_out_item                 r;
        ph  = {s.pin_a, s.pin_b};
        det = '0;
        if (ph != enc_ph) begin
            case (enc_ph)
                PH_11:   fwd = (ph == PH_01);
                PH_01:   fwd = (ph == PH_00);
                PH_00:   fwd = (ph == PH_10);
                default: fwd = (ph == PH_11);
            endcase
            if (fwd) begin
                if (ticks != TICK_MAX) ticks = ticks + 16'sd1;
            end else if (ticks != TICK_MIN) begin
                ticks = ticks - 16'sd1;
            end
            enc_ph = ph;
        end

        if (s.switch_down != raw_q) begin
            quiet_ms = '0;
            raw_q    = s.switch_down;
        end else if (s.ms_tick && quiet_ms != MS_MAX) begin
            quiet_ms = quiet_ms + 16'd1;
        end
        if (s.ms_tick && sw_held && hold_ms != MS_MAX)
            hold_ms = hold_ms + 16'd1;

        if (quiet_ms > {6'd0, deb_lim}) begin
            if (s.switch_down && !sw_held) begin
                sw_held   = 1'b1;
                hold_ms   = '0;
                long_done = 1'b0;
            end else if (!s.switch_down && sw_held) begin
                sw_held = 1'b0;
                if (!long_done) short_evt = 1'b1;
            end
        end
        if (sw_held && !long_done && hold_ms >= {2'd0, long_lim}) begin
            long_done = 1'b1;
            long_evt  = 1'b1;
        end

        // whole detents only, truncated toward zero; remainder stays
        if (s.take) begin
            det   = DELTA_W'(ticks / DETENT_TICKS);
            ticks = DELTA_W'(ticks - det * DETENT_TICKS);
        end
        r.delta      = det;
        r.pressed    = short_evt;
        r.long_press = long_evt;
        r.held       = sw_held;
        if (s.take) begin
            short_evt = 1'b0;
            long_evt  = 1'b0;
        end
        return r;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            deb_lim   = DEBOUNCE_RST;
            long_lim  = LONG_PRESS_RST;
            enc_ph    = PH_11;
            ticks     = '0;
            raw_q     = 1'b0;
            sw_held   = 1'b0;
            quiet_ms  = '0;
            hold_ms   = '0;
            long_done = 1'b0;
            short_evt = 1'b0;
            long_evt  = 1'b0;
            readout_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_DEBOUNCE) deb_lim = i_pwdata[DEB_W-1:0];
                else long_lim = i_pwdata[LONG_W-1:0];
            end
            if (i_out_valid && i_out_ready) begin
                if (readout_due.size() == 0) begin
                    $error("readout with nothing expected: delta %0d", i_out_item.delta);
                    o_fail_count++;
                end else begin
                    want = readout_due.pop_front();
                    if (i_out_item.delta !== want.delta) begin
                        $error("delta: expected %0d, got %0d", want.delta, i_out_item.delta);
                        o_fail_count++;
                    end
                    if (i_out_item.pressed !== want.pressed) begin
                        $error("pressed: expected %0b, got %0b",
                               want.pressed, i_out_item.pressed);
                        o_fail_count++;
                    end
                    if (i_out_item.long_press !== want.long_press) begin
                        $error("long_press: expected %0b, got %0b",
                               want.long_press, i_out_item.long_press);
                        o_fail_count++;
                    end
                    if (i_out_item.held !== want.held) begin
                        $error("held: expected %0b, got %0b", want.held, i_out_item.held);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                readout_due.push_back(next_readout(i_in_item));
        end
        o_pending = readout_due.size();
    end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the rotary encoder unit. All prediction and
// comparison lives in the checker instantiated next to the block.
module tb;
    import rews_pkg::*;

    // no item moving on either channel for this long means a hang
    localparam int STALL_LIMIT = 2000;
    // results trail their items through the input and output registers; pad the tail
    localparam int TAIL_CYCLES = 6;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    t_in_item          in_item;
    logic              out_valid;
    logic              out_ready;
    t_out_item         out_item;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_W-1:0]  pwdata;
    logic [APB_W-1:0]  prdata;
    logic              pready;

    int                fail_count;
    int                pending;
    int                idle_cycles;

    // generator state shared by the stimulus tasks and processes
    logic [1:0]        enc_ph;       // pin phase last driven
    logic              sw_lvl;       // switch level the "finger" intends
    int                bounce_left;  // samples of contact bounce still to come
    logic              calm;         // near-zero idling, for the closing sweep
    int                no_gap_left;  // sender burst with no gaps
    int                stall_left;
    int                free_left;    // receiver stretch with no stalls

    rotary_encoder_with_switch_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    rews_readout_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 4 ns period
    initial clk = 1'b0;
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Next phase one clockwise Gray step on: 11 -> 01 -> 00 -> 10 -> 11.
    function automatic logic [1:0] cw_next(input logic [1:0] ph);
        case (ph)
            PH_11:   return PH_01;
            PH_01:   return PH_00;
            PH_00:   return PH_10;
            default: return PH_11;
        endcase
    endfunction

    function automatic logic [1:0] ccw_next(input logic [1:0] ph);
        case (ph)
            PH_11:   return PH_10;
            PH_10:   return PH_00;
            PH_00:   return PH_01;
            default: return PH_11;
        endcase
    endfunction

    function automatic t_in_item item_of(input logic [1:0] ph, input logic sw,
                                         input logic tick, input logic take);
        t_in_item it;
        it.pin_a       = ph[1];
        it.pin_b       = ph[0];
        it.switch_down = sw;
        it.ms_tick     = tick;
        it.take        = take;
        return it;
    endfunction

    // Offer one item after a random gap and return at the edge it is taken.
    // Called at a rising edge; valid is only lowered when a gap is wanted,
    // so back-to-back items keep valid high.
    task automatic send(input t_in_item it);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (calm) begin
            gap = int'(r == 0);
        end else if (no_gap_left > 0) begin
            gap = 0;
            no_gap_left--;
        end else if (r < 3) begin
            gap = 0;
            no_gap_left = $urandom_range(20, 80);
        end else if (r < 45) begin
            gap = 0;
        end else if (r < 85) begin
            gap = $urandom_range(1, 3);
        end else if (r < 97) begin
            gap = $urandom_range(4, 10);
        end else begin
            gap = $urandom_range(20, 60);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        enc_ph = {it.pin_a, it.pin_b};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Stop offering and wait until every predicted readout has come back.
    // The first edge lets the checker see the last acceptance; a stale
    // count afterwards can only be too high, which only delays the return.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the write lands at the access edge.
    task automatic write_reg(input logic idx, input logic [APB_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Receiver pacing: mostly short stalls, a few long ones, and stretches
    // where it takes every readout.
    always @(posedge clk) begin : sink_pace
        int r;
        r = $urandom_range(0, 99);
        if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left--;
        end else begin
            out_ready <= 1'b1;
            if (calm) begin
                stall_left = int'(r == 0);
            end else if (free_left > 0) begin
                free_left--;
            end else if (r < 3) begin
                free_left = $urandom_range(20, 80);
            end else if (r < 55) begin
                stall_left = 0;
            end else if (r < 88) begin
                stall_left = $urandom_range(1, 3);
            end else if (r < 98) begin
                stall_left = $urandom_range(4, 12);
            end else begin
                stall_left = $urandom_range(20, 60);
            end
        end
    end

    // Hang detector: counts cycles where neither channel moves an item.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        // per-phase register values and switch/tick behavior
        int         deb_tab[6];
        int         long_tab[6];
        int         count_tab[6];
        int         toggle_tab[6];  // chance per thousand that the finger moves
        int         tick_tab[6];    // percent of samples carrying a ms tick
        int         r;
        logic [1:0] ph;
        logic       sw;

        deb_tab    = '{0,   3,   50,  1,   1000,  10};
        long_tab   = '{0,   10,  600, 2,   10000, 40};
        count_tab  = '{250, 350, 250, 250, 100,   200};
        toggle_tab = '{40,  25,  8,   30,  20,    15};
        tick_tab   = '{50,  60,  90,  70,  50,    80};

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_item     = '0;
        out_ready   = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        idle_cycles = 0;
        enc_ph      = PH_11;
        sw_lvl      = 1'b0;
        bounce_left = 0;
        calm        = 1'b0;
        no_gap_left = 0;
        stall_left  = 0;
        free_left   = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part: zero debounce and immediate long press ----
        write_reg(REG_DEBOUNCE, 32'd0);
        write_reg(REG_LONG_PRESS, 32'd0);

        // one full clockwise turn, then take one detent
        send(item_of(PH_01, 1'b0, 1'b0, 1'b0));
        send(item_of(PH_00, 1'b0, 1'b0, 1'b0));
        send(item_of(PH_10, 1'b0, 1'b0, 1'b0));
        send(item_of(PH_11, 1'b0, 1'b0, 1'b1));
        // one full turn back
        send(item_of(PH_10, 1'b0, 1'b0, 1'b0));
        send(item_of(PH_00, 1'b0, 1'b0, 1'b0));
        send(item_of(PH_01, 1'b0, 1'b0, 1'b0));
        send(item_of(PH_11, 1'b0, 1'b0, 1'b0));
        // two-bit jumps both ways count as reverse steps
        send(item_of(PH_00, 1'b0, 1'b0, 1'b0));
        send(item_of(PH_11, 1'b0, 1'b0, 1'b1));
        // leftover of -2 ticks truncates to zero detents
        send(item_of(PH_11, 1'b0, 1'b0, 1'b1));
        // press: raw change, then one stable tick registers the press and fires long press
        send(item_of(PH_11, 1'b1, 1'b0, 1'b0));
        send(item_of(PH_11, 1'b1, 1'b1, 1'b0));
        send(item_of(PH_11, 1'b1, 1'b1, 1'b1));
        // bounce without ticks, then a release after a long press
        send(item_of(PH_11, 1'b0, 1'b0, 1'b0));
        send(item_of(PH_11, 1'b1, 1'b0, 1'b0));
        send(item_of(PH_11, 1'b0, 1'b1, 1'b0));
        send(item_of(PH_11, 1'b0, 1'b1, 1'b0));
        send(item_of(PH_11, 1'b1, 1'b1, 1'b1));
        settle();

        // short press needs a nonzero long press time
        write_reg(REG_LONG_PRESS, 32'd3);
        send(item_of(PH_11, 1'b1, 1'b1, 1'b0));
        send(item_of(PH_11, 1'b1, 1'b1, 1'b0));
        send(item_of(PH_11, 1'b0, 1'b1, 1'b0));
        send(item_of(PH_11, 1'b0, 1'b1, 1'b0));
        send(item_of(PH_11, 1'b0, 1'b0, 1'b1));
        send(item_of(PH_11, 1'b0, 1'b0, 1'b1));
        settle();

        // ---- random part: mostly clean rotation and clean presses ----
        // Each phase gets its own register pair; the sender drains fully
        // before the next pair is written.
        for (int p = 0; p < 6; p++) begin
            write_reg(REG_DEBOUNCE, deb_tab[p]);
            write_reg(REG_LONG_PRESS, long_tab[p]);
            for (int n = 0; n < count_tab[p]; n++) begin
                r = $urandom_range(0, 99);
                if (r < 55) ph = cw_next(enc_ph);
                else if (r < 75) ph = ccw_next(enc_ph);
                else if (r < 85) ph = enc_ph;
                else if (r < 95) ph = ~enc_ph;
                else ph = 2'($urandom);
                // finger moves now and then, with a short burst of bounce
                if ($urandom_range(0, 999) < toggle_tab[p]) begin
                    sw_lvl      = ~sw_lvl;
                    bounce_left = $urandom_range(0, 4);
                end
                if (bounce_left > 0) begin
                    sw = 1'($urandom);
                    bounce_left--;
                end else begin
                    sw = sw_lvl;
                end
                send(item_of(ph, sw, $urandom_range(0, 99) < tick_tab[p],
                             $urandom_range(0, 7) == 0));
            end
            settle();
        end

        // ---- closing sweep ----
        // All-ones writes leave the widest register values, so the switch
        // cannot settle here. A steady spin one way, then twice as far
        // back, with a tick on every sample, checks the detent takes and
        // the leftover ticks; a short release ends it.
        write_reg(REG_DEBOUNCE, 32'hFFFF_FFFF);
        write_reg(REG_LONG_PRESS, 32'hFFFF_FFFF);
        calm = 1'b1;
        send(item_of(enc_ph, 1'b1, 1'b1, 1'b1));
        for (int n = 0; n < 40; n++)
            send(item_of(cw_next(enc_ph), 1'b1, 1'b1, n == 39));
        for (int n = 0; n < 80; n++)
            send(item_of(ccw_next(enc_ph), 1'b1, 1'b1, n == 79));
        for (int n = 0; n < 10; n++)
            send(item_of(enc_ph, 1'b0, 1'b1, n == 9));
        settle();

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
design/rews_pkg.sv
design/rews_regs.sv
design/rews_quad.sv
design/rews_switch.sv
design/rotary_encoder_with_switch_unit.sv
design/rews_checker.sv
tb/sv/rews_readout_checker.sv
tb/sv/tb.sv
